### rtl/core/rxff_pkg.sv
// ----------------------------------------------------------------------------
// rxff_pkg
// Shared types and constants of the receive FIFO with XON/XOFF flow control.
// ----------------------------------------------------------------------------
`default_nettype none

package rxff_pkg;

  localparam int unsigned DEPTH_DEF = 32;

  localparam logic [7:0] XON_CHAR  = 8'h11;
  localparam logic [7:0] XOFF_CHAR = 8'h13;

  localparam logic [5:0] HIGH_MARK_RST = 6'd21;
  localparam logic [5:0] LOW_MARK_RST  = 6'd15;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_HIGH_MARK = 1'b0;
  localparam logic REG_LOW_MARK  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       flow_send;
    logic [7:0] flow_char;
    logic       overflow_drop;
    logic [5:0] fill_level;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/rx_fifo_xon_xoff_flow_control_unit.sv
// ----------------------------------------------------------------------------
// rx_fifo_xon_xoff_flow_control_unit
// Receive byte FIFO with XON/XOFF software flow control and hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_word: one word per step, either a byte from the line
//   (cmd 0) or a read request (cmd 1). out_valid/out_stall/out_word: exactly
//   one result word per input word, in order: popped byte, flow character
//   request (XON 0x11 / XOFF 0x13), drop flag and fill level after the step.
//   cfg_valid/cfg_index/cfg_data write the high mark (0) or low mark (1);
//   cfg_ready is always high. Write marks only while the block is idle.
// Sequence:
//   A word is taken in the idle state (store read issued there) and the update
//   runs in the following execute state once the output slot is free, loading
//   the output register from the registered store read. No new word is taken
//   until the update of the last one has run.
// Reset clears pointers, count, flow flags and the output valid flag; marks
// return to 21 and 15. Store contents are not cleared. While out_stall holds
// a result, one more word may be taken but its update waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_fifo_xon_xoff_flow_control_unit
  import rxff_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data
);

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  rxff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (ctl_cmd)
  );

  rxff_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (ctl_cmd),
    .status    (dp_status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

### rtl/core/rxff_ctrl.sv
// ----------------------------------------------------------------------------
// rxff_ctrl
// Sequencer: takes one word, then runs the update once the output slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rxff_ctrl
  import rxff_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       slot_free;

  assign slot_free = !status.out_busy || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.execute = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/rxff_dp.sv
// ----------------------------------------------------------------------------
// rxff_dp
// Byte store, pointers, fill count, flow-control flags, marks, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rxff_dp
  import rxff_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_word_t   in_word,
  input  wire ctl_cmd_t   cmd,
  output dp_status_t      status,
  input  wire logic       out_stall,
  output logic            out_valid,
  output out_word_t       out_word,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;

  logic [7:0]    mem [DEPTH];

  in_word_t      item_r;
  logic [7:0]    rdata_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          xoff_done_r, xoff_done_nxt;
  logic          xon_done_r, xon_done_nxt;
  logic [5:0]    high_mark_r;
  logic [5:0]    low_mark_r;
  logic          out_valid_r;
  out_word_t     out_word_r, out_word_nxt;
  logic          mem_we;

  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] high_ext;
  logic [CMPW-1:0] low_ext;
  logic [CMPW-1:0] level_ext;
  logic            full;
  logic            empty;

  assign count_ext = CMPW'(count_r);
  assign high_ext  = CMPW'(high_mark_r);
  assign low_ext   = CMPW'(low_mark_r);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    count_nxt     = count_r;
    xoff_done_nxt = xoff_done_r;
    xon_done_nxt  = xon_done_r;
    mem_we        = 1'b0;
    out_word_nxt  = '0;
    if (item_r.cmd == CMD_RX) begin
      if (count_ext >= high_ext) begin
        if (!xoff_done_r) begin
          out_word_nxt.flow_send = 1'b1;
          out_word_nxt.flow_char = XOFF_CHAR;
          xoff_done_nxt          = 1'b1;
        end
        xon_done_nxt = 1'b0;
      end
      if (!full) begin
        mem_we     = cmd.execute;
        wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
        count_nxt  = count_r + 1'b1;
      end else begin
        out_word_nxt.overflow_drop = 1'b1;
      end
    end else begin
      if (count_ext <= low_ext && !xon_done_r) begin
        out_word_nxt.flow_send = 1'b1;
        out_word_nxt.flow_char = XON_CHAR;
        xon_done_nxt           = 1'b1;
        xoff_done_nxt          = 1'b0;
      end
      if (!empty) begin
        out_word_nxt.read_data  = rdata_r;
        out_word_nxt.read_valid = 1'b1;
        rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
        count_nxt  = count_r - 1'b1;
      end
    end
    level_ext               = CMPW'(count_nxt);
    out_word_nxt.fill_level = level_ext[5:0];
  end

  // store write and registered read; the read is issued when the word is taken
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= item_r.rx_byte;
    end
    if (cmd.capture) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_word;
    end
    if (cmd.execute) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      xoff_done_r <= 1'b0;
      xon_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      high_mark_r <= HIGH_MARK_RST;
      low_mark_r  <= LOW_MARK_RST;
    end else begin
      if (cmd.execute) begin
        wr_ptr_r    <= wr_ptr_nxt;
        rd_ptr_r    <= rd_ptr_nxt;
        count_r     <= count_nxt;
        xoff_done_r <= xoff_done_nxt;
        xon_done_r  <= xon_done_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_HIGH_MARK) begin
          high_mark_r <= cfg_data;
        end else begin
          low_mark_r <= cfg_data;
        end
      end
    end
  end

  assign status.out_busy = out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;

endmodule

`default_nettype wire
